// File: rtl/core/arsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arsc_pkg
// Shared types and constants of the anchored rectangle scaler: anchor codes,
// register indexes, datapath widths and the payload records that travel
// alongside the two divider pipelines.
// ----------------------------------------------------------------------------
package arsc_pkg;

  // Field widths
  localparam int SZ_W  = 14;   // screen and reference sizes
  localparam int CRD_W = 16;   // reference-space coordinates
  localparam int TRM_W = 18;   // anchor-adjusted terms before scaling
  localparam int A_NW  = 33;   // numerators of the first divider
  localparam int B_NW  = 36;   // numerators of the second (centre) divider
  localparam int OUT_W = 32;   // result coordinates

  // Anchor codes
  localparam logic [2:0] ANCH_TL = 3'd0;
  localparam logic [2:0] ANCH_TR = 3'd1;
  localparam logic [2:0] ANCH_BL = 3'd2;
  localparam logic [2:0] ANCH_BR = 3'd3;
  localparam logic [2:0] ANCH_CT = 3'd4;

  // Register indexes (paddr[2])
  localparam logic REG_REF_W = 1'b0;
  localparam logic REG_REF_H = 1'b1;

  // Decoded placement of one request
  typedef struct packed {
    logic right;
    logic bottom;
    logic center;
  } arsc_flags_t;

  // Side data carried through the first divider
  typedef struct packed {
    logic [A_NW-1:0] cxn;
    logic [A_NW-1:0] cyn;
    logic [SZ_W-1:0] sw;
    logic [SZ_W-1:0] sh;
    logic [SZ_W-1:0] sden;
    logic            bad;
    arsc_flags_t     flags;
  } arsc_pa_t;

  // Side data carried through the second divider
  typedef struct packed {
    logic [OUT_W-1:0] rwid;
    logic [OUT_W-1:0] rhgt;
    logic [OUT_W-1:0] qx;
    logic [OUT_W-1:0] qy;
    logic [SZ_W-1:0]  sw;
    logic [SZ_W-1:0]  sh;
    logic             bad;
    arsc_flags_t      flags;
  } arsc_pb_t;

endpackage

// File: rtl/core/arsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arsc_div
// Pipelined rounding divider: q = round(num / den), halves away from zero,
// for several lanes sharing one divisor. One restoring quotient bit per
// stage; a new request may enter every cycle.
// ----------------------------------------------------------------------------
module arsc_div #(
  parameter int LANES = 2,
  parameter int NW    = 33,
  parameter int DW    = 14,
  parameter int PW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] num_i [LANES],
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          out_vld,
  output logic [NW:0]   quo_o [LANES],
  output logic [PW-1:0] pay_o
);

  localparam int QW = NW + 1;   // width of 2*|num| + den
  localparam int VW = DW + 1;   // width of 2*den

  logic [QW:0]        vld_r;
  logic [QW-1:0]      work_r [QW+1][LANES];
  logic [VW-1:0]      rem_r  [QW+1][LANES];
  logic [LANES-1:0]   neg_r  [QW+1];
  logic [VW-1:0]      dv_r   [QW+1];
  logic [PW-1:0]      pay_r  [QW+1];
  logic               ovld_r;
  logic [NW:0]        quo_r  [LANES];
  logic [PW-1:0]      opay_r;

  // Entry: fold the rounding into the dividend, (2|n| + d) / 2d
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    dv_r[0]  <= {den_i, 1'b0};
    pay_r[0] <= pay_i;
    for (int l = 0; l < LANES; l++) begin
      neg_r[0][l] <= num_i[l][NW-1];
      work_r[0][l] <= {(num_i[l][NW-1] ? (~num_i[l] + 1'b1) : num_i[l]), 1'b0}
                      + QW'(den_i);
      rem_r[0][l] <= '0;
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [VW:0]   t_nxt  [LANES];
    logic [LANES-1:0] ge_nxt;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t_nxt[l]  = {rem_r[k-1][l], work_r[k-1][l][QW-1]};
        ge_nxt[l] = (t_nxt[l] >= {1'b0, dv_r[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      dv_r[k]  <= dv_r[k-1];
      pay_r[k] <= pay_r[k-1];
      neg_r[k] <= neg_r[k-1];
      for (int l = 0; l < LANES; l++) begin
        rem_r[k][l]  <= ge_nxt[l] ? VW'(t_nxt[l] - {1'b0, dv_r[k-1]}) : VW'(t_nxt[l]);
        work_r[k][l] <= {work_r[k-1][l][QW-2:0], ge_nxt[l]};
      end
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r[QW];
    end
    opay_r <= pay_r[QW];
    for (int l = 0; l < LANES; l++) begin
      quo_r[l] <= neg_r[QW][l] ? (~{1'b0, work_r[QW][l][NW-1:0]} + 1'b1)
                               : {1'b0, work_r[QW][l][NW-1:0]};
    end
  end

  assign out_vld = ovld_r;
  assign quo_o   = quo_r;
  assign pay_o   = opay_r;

endmodule

// File: rtl/core/anchored_rect_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchored_rect_scaler
// Maps a reference-space rectangle onto a screen with a uniform scale and
// an anchor, rounding halves away from zero.
// ----------------------------------------------------------------------------
// Every request is taken when start is high (busy is always low) and its
// result appears on out_strobe; one request may be issued every cycle. Each
// result is shown for one cycle only and cannot be held off, so the receiver
// must take it when out_strobe is high. The path holds two one-bit-per-stage
// divider pipelines: 36 stages for the size and margin quotients, then 39 for
// the centre placement, which needs the rounded size first. Reference sizes
// must be written over the APB port while no request is in flight.
// ----------------------------------------------------------------------------
module anchored_rect_scaler
  import arsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // request
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_entry_present,
  input  logic signed [CRD_W-1:0] in_rect_left,
  input  logic signed [CRD_W-1:0] in_rect_top,
  input  logic signed [CRD_W-1:0] in_rect_width,
  input  logic signed [CRD_W-1:0] in_rect_height,
  input  logic [2:0]              in_anchor_kind,
  input  logic [SZ_W-1:0]         in_screen_width,
  input  logic [SZ_W-1:0]         in_screen_height,
  // result
  output logic                    out_strobe,
  output logic                    out_valid_res,
  output logic signed [OUT_W-1:0] out_left,
  output logic signed [OUT_W-1:0] out_top,
  output logic signed [OUT_W-1:0] out_width,
  output logic signed [OUT_W-1:0] out_height,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int LAT = A_NW + B_NW + 12;

  // ---------------- configuration registers ----------------
  logic [SZ_W-1:0] ref_w_r, ref_h_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_w_r <= '0;
      ref_h_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_REF_W: ref_w_r <= pwdata[SZ_W-1:0];
        REG_REF_H: ref_h_r <= pwdata[SZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_REF_W: prdata = {{(32-SZ_W){1'b0}}, ref_w_r};
      REG_REF_H: prdata = {{(32-SZ_W){1'b0}}, ref_h_r};
      default:   prdata = '0;
    endcase
  end

  // ---------------- stage 1: capture request ----------------
  logic                    s1_vld_r, s1_pres_r;
  logic signed [CRD_W-1:0] s1_x_r, s1_y_r, s1_w_r, s1_h_r;
  logic [2:0]              s1_anch_r;
  logic [SZ_W-1:0]         s1_sw_r, s1_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_pres_r <= in_entry_present;
    s1_x_r    <= in_rect_left;
    s1_y_r    <= in_rect_top;
    s1_w_r    <= in_rect_width;
    s1_h_r    <= in_rect_height;
    s1_anch_r <= in_anchor_kind;
    s1_sw_r   <= in_screen_width;
    s1_sh_r   <= in_screen_height;
  end

  // ---------------- stage 2: pick scale, anchor terms ----------------
  logic [2*SZ_W-1:0]       cross_w, cross_h;
  logic                    use_w_nxt, bad_nxt;
  arsc_flags_t             flags_nxt;
  logic signed [TRM_W-1:0] xe, ye, we, he, rwe, rhe;
  logic signed [TRM_W-1:0] tx_nxt, ty_nxt, cx_nxt, cy_nxt;

  always_comb begin
    cross_w   = s1_sw_r * ref_h_r;
    cross_h   = s1_sh_r * ref_w_r;
    use_w_nxt = (cross_w <= cross_h);
    bad_nxt   = !s1_pres_r || (ref_w_r == '0) || (ref_h_r == '0) ||
                (s1_sw_r == '0) || (s1_sh_r == '0);
    flags_nxt.center = (s1_anch_r == ANCH_CT);
    flags_nxt.right  = (s1_anch_r == ANCH_TR) || (s1_anch_r == ANCH_BR);
    flags_nxt.bottom = (s1_anch_r == ANCH_BL) || (s1_anch_r == ANCH_BR);
    xe  = TRM_W'(s1_x_r);
    ye  = TRM_W'(s1_y_r);
    we  = TRM_W'(s1_w_r);
    he  = TRM_W'(s1_h_r);
    rwe = $signed({{(TRM_W-SZ_W){1'b0}}, ref_w_r});
    rhe = $signed({{(TRM_W-SZ_W){1'b0}}, ref_h_r});
    tx_nxt = flags_nxt.right  ? (rwe - xe - we) : xe;
    ty_nxt = flags_nxt.bottom ? (rhe - ye - he) : ye;
    cx_nxt = (xe <<< 1) + we - rwe;
    cy_nxt = (ye <<< 1) + he - rhe;
  end

  logic                    s2_vld_r, s2_bad_r;
  arsc_flags_t             s2_flags_r;
  logic [SZ_W-1:0]         s2_snum_r, s2_sden_r, s2_sw_r, s2_sh_r;
  logic signed [CRD_W-1:0] s2_w_r, s2_h_r;
  logic signed [TRM_W-1:0] s2_tx_r, s2_ty_r, s2_cx_r, s2_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_bad_r   <= bad_nxt;
    s2_flags_r <= flags_nxt;
    s2_snum_r  <= use_w_nxt ? s1_sw_r : s1_sh_r;
    s2_sden_r  <= use_w_nxt ? ref_w_r : ref_h_r;
    s2_sw_r    <= s1_sw_r;
    s2_sh_r    <= s1_sh_r;
    s2_w_r     <= s1_w_r;
    s2_h_r     <= s1_h_r;
    s2_tx_r    <= tx_nxt;
    s2_ty_r    <= ty_nxt;
    s2_cx_r    <= cx_nxt;
    s2_cy_r    <= cy_nxt;
  end

  // ---------------- stage 3: scale numerators ----------------
  logic signed [SZ_W:0]   snum_s;
  logic                   s3_vld_r;
  logic [A_NW-1:0]        s3_num_r [4];
  arsc_pa_t               s3_pay_r;

  assign snum_s = $signed({1'b0, s2_snum_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_num_r[0]    <= A_NW'(s2_w_r * snum_s);
    s3_num_r[1]    <= A_NW'(s2_h_r * snum_s);
    s3_num_r[2]    <= A_NW'(s2_tx_r * snum_s);
    s3_num_r[3]    <= A_NW'(s2_ty_r * snum_s);
    s3_pay_r.cxn   <= A_NW'(s2_cx_r * snum_s);
    s3_pay_r.cyn   <= A_NW'(s2_cy_r * snum_s);
    s3_pay_r.sw    <= s2_sw_r;
    s3_pay_r.sh    <= s2_sh_r;
    s3_pay_r.sden  <= s2_sden_r;
    s3_pay_r.bad   <= s2_bad_r;
    s3_pay_r.flags <= s2_flags_r;
  end

  // ---------------- divider A: sizes and margins ----------------
  logic            da_vld;
  logic [A_NW:0]   da_quo [4];
  logic [$bits(arsc_pa_t)-1:0] da_pay_bits;
  arsc_pa_t        da_pay;

  arsc_div #(
    .LANES (4),
    .NW    (A_NW),
    .DW    (SZ_W),
    .PW    ($bits(arsc_pa_t))
  ) u_div_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s3_vld_r),
    .num_i   (s3_num_r),
    .den_i   (s3_pay_r.sden),
    .pay_i   (s3_pay_r),
    .out_vld (da_vld),
    .quo_o   (da_quo),
    .pay_o   (da_pay_bits)
  );

  assign da_pay = arsc_pa_t'(da_pay_bits);

  // ---------------- stage 4: screen slack times divisor ----------------
  localparam int DF_W = A_NW + 2;
  logic signed [DF_W-1:0]       dx_nxt, dy_nxt;
  logic signed [SZ_W:0]         sden_s;
  logic                         s4_vld_r;
  logic [B_NW-1:0]              s4_px_r, s4_py_r;
  logic [A_NW-1:0]              s4_cxn_r, s4_cyn_r;
  logic [SZ_W-1:0]              s4_sden_r;
  arsc_pb_t                     s4_pb_r;

  always_comb begin
    sden_s = $signed({1'b0, da_pay.sden});
    dx_nxt = $signed({{(DF_W-SZ_W){1'b0}}, da_pay.sw}) - DF_W'($signed(da_quo[0]));
    dy_nxt = $signed({{(DF_W-SZ_W){1'b0}}, da_pay.sh}) - DF_W'($signed(da_quo[1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= da_vld;
    end
    s4_px_r        <= B_NW'(dx_nxt * sden_s);
    s4_py_r        <= B_NW'(dy_nxt * sden_s);
    s4_cxn_r       <= da_pay.cxn;
    s4_cyn_r       <= da_pay.cyn;
    s4_sden_r      <= da_pay.sden;
    s4_pb_r.rwid   <= da_quo[0][OUT_W-1:0];
    s4_pb_r.rhgt   <= da_quo[1][OUT_W-1:0];
    s4_pb_r.qx     <= da_quo[2][OUT_W-1:0];
    s4_pb_r.qy     <= da_quo[3][OUT_W-1:0];
    s4_pb_r.sw     <= da_pay.sw;
    s4_pb_r.sh     <= da_pay.sh;
    s4_pb_r.bad    <= da_pay.bad;
    s4_pb_r.flags  <= da_pay.flags;
  end

  // ---------------- stage 5: centre numerators ----------------
  logic             s5_vld_r;
  logic [B_NW-1:0]  s5_num_r [2];
  logic [SZ_W:0]    s5_den_r;
  arsc_pb_t         s5_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    s5_num_r[0] <= B_NW'($signed(s4_cxn_r)) + s4_px_r;
    s5_num_r[1] <= B_NW'($signed(s4_cyn_r)) + s4_py_r;
    s5_den_r    <= {s4_sden_r, 1'b0};
    s5_pb_r     <= s4_pb_r;
  end

  // ---------------- divider B: centre placement ----------------
  logic            db_vld;
  logic [B_NW:0]   db_quo [2];
  logic [$bits(arsc_pb_t)-1:0] db_pay_bits;
  arsc_pb_t        db_pay;

  arsc_div #(
    .LANES (2),
    .NW    (B_NW),
    .DW    (SZ_W + 1),
    .PW    ($bits(arsc_pb_t))
  ) u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s5_vld_r),
    .num_i   (s5_num_r),
    .den_i   (s5_den_r),
    .pay_i   (s5_pb_r),
    .out_vld (db_vld),
    .quo_o   (db_quo),
    .pay_o   (db_pay_bits)
  );

  assign db_pay = arsc_pb_t'(db_pay_bits);

  // ---------------- stage 6: place and drive result ----------------
  logic [OUT_W-1:0] sw32, sh32, left_nxt, top_nxt;
  logic             strobe_r, valid_r;
  logic [OUT_W-1:0] left_r, top_r, width_r, height_r;

  always_comb begin
    sw32 = {{(OUT_W-SZ_W){1'b0}}, db_pay.sw};
    sh32 = {{(OUT_W-SZ_W){1'b0}}, db_pay.sh};
    if (db_pay.flags.center) begin
      left_nxt = db_quo[0][OUT_W-1:0];
      top_nxt  = db_quo[1][OUT_W-1:0];
    end else begin
      left_nxt = db_pay.flags.right  ? (sw32 - db_pay.qx - db_pay.rwid) : db_pay.qx;
      top_nxt  = db_pay.flags.bottom ? (sh32 - db_pay.qy - db_pay.rhgt) : db_pay.qy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      strobe_r <= db_vld;
      valid_r  <= db_vld && !db_pay.bad;
    end
    left_r   <= db_pay.bad ? '0 : left_nxt;
    top_r    <= db_pay.bad ? '0 : top_nxt;
    width_r  <= db_pay.bad ? '0 : db_pay.rwid;
    height_r <= db_pay.bad ? '0 : db_pay.rhgt;
  end

  assign out_strobe    = strobe_r;
  assign out_valid_res = valid_r;
  assign out_left      = $signed(left_r);
  assign out_top       = $signed(top_r);
  assign out_width     = $signed(width_r);
  assign out_height    = $signed(height_r);

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_strobe)
    else $error("request did not emerge after the fixed latency");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_valid_res |->
      out_left == '0 && out_top == '0 && out_width == '0 && out_height == '0)
    else $error("invalid result carries non-zero coordinates");

  a_valid_strobe: assert property (@(posedge clk)
    !out_strobe |-> !out_valid_res)
    else $error("valid flag raised without a result strobe");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe after reset");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && paddr[2] == REG_REF_W |=> ref_w_r == $past(pwdata[SZ_W-1:0]))
    else $error("reference width write lost");
`endif

endmodule

// File: tb/sv/anchored_rect_scaler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchored_rect_scaler_test
// Drives layout requests into the anchored rectangle scaler under several
// reference sizes, predicts each placed rectangle with exact integer maths
// and compares every strobed result field by field in arrival order.
// ----------------------------------------------------------------------------
module anchored_rect_scaler_test;
  import arsc_pkg::*;

  localparam int LATENCY = 81;

  typedef struct packed {
    logic              ok;
    logic signed [31:0] left;
    logic signed [31:0] top;
    logic signed [31:0] wid;
    logic signed [31:0] hgt;
  } placed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_entry_present = 1'b0;
  logic signed [CRD_W-1:0] in_rect_left = '0, in_rect_top = '0;
  logic signed [CRD_W-1:0] in_rect_width = '0, in_rect_height = '0;
  logic [2:0] in_anchor_kind = ANCH_TL;
  logic [SZ_W-1:0] in_screen_width = '0, in_screen_height = '0;
  logic out_strobe, out_valid_res;
  logic signed [OUT_W-1:0] out_left, out_top, out_width, out_height;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predictor copy of the reference size registers
  logic [SZ_W-1:0] ref_w_q = '0, ref_h_q = '0;
  placed_t pending_rects[$];
  int errors = 0;
  bit steady = 1'b0;

  anchored_rect_scaler dut (.*);

  always #6 clk = ~clk;

  // Halves away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic placed_t place_rect(logic pres, logic signed [15:0] x16,
      logic signed [15:0] y16, logic signed [15:0] w16, logic signed [15:0] h16,
      logic [2:0] anch, logic [13:0] sw14, logic [13:0] sh14);
    longint rw, rh, sw, sh, x, y, w, h, num, den, wd, ht, px, py;
    placed_t r;
    r = '0;
    rw = ref_w_q; rh = ref_h_q; sw = sw14; sh = sh14;
    x = x16; y = y16; w = w16; h = h16;
    if (!pres || rw == 0 || rh == 0 || sw == 0 || sh == 0) return r;
    if (sw * rh <= sh * rw) begin
      num = sw; den = rw;
    end else begin
      num = sh; den = rh;
    end
    wd = round_div(w * num, den);
    ht = round_div(h * num, den);
    if (anch == ANCH_CT) begin
      px = round_div((2 * x + w - rw) * num + (sw - wd) * den, 2 * den);
      py = round_div((2 * y + h - rh) * num + (sh - ht) * den, 2 * den);
    end else begin
      if (anch == ANCH_TR || anch == ANCH_BR)
        px = sw - round_div((rw - (x + w)) * num, den) - wd;
      else
        px = round_div(x * num, den);
      if (anch == ANCH_BL || anch == ANCH_BR)
        py = sh - round_div((rh - (y + h)) * num, den) - ht;
      else
        py = round_div(y * num, den);
    end
    r.ok = 1'b1;
    r.left = px[31:0]; r.top = py[31:0]; r.wid = wd[31:0]; r.hgt = ht[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    errors++;
    $display("%0t: %s mismatch: got %0d expected %0d", $time, what, got, exp);
  endtask

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    placed_t e;
    if (rst_n && out_strobe) begin
      if (pending_rects.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding", $time);
      end else begin
        e = pending_rects.pop_front();
        if (out_valid_res !== e.ok) report_mismatch("valid_res", out_valid_res, e.ok);
        if (out_left !== e.left) report_mismatch("left", out_left, e.left);
        if (out_top !== e.top) report_mismatch("top", out_top, e.top);
        if (out_width !== e.wid) report_mismatch("width", out_width, e.wid);
        if (out_height !== e.hgt) report_mismatch("height", out_height, e.hgt);
      end
    end
  end

  // Idle at random, except during steady stretches; drop start while idling
  task automatic maybe_idle();
    while (!steady && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_request(logic pres, logic [15:0] x, logic [15:0] y,
      logic [15:0] w, logic [15:0] h, logic [2:0] anch, logic [13:0] sw,
      logic [13:0] sh);
    maybe_idle();
    start <= 1'b1;
    in_entry_present <= pres;
    in_rect_left <= x; in_rect_top <= y;
    in_rect_width <= w; in_rect_height <= h;
    in_anchor_kind <= anch;
    in_screen_width <= sw; in_screen_height <= sh;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rects = {pending_rects, place_rect(pres, x, y, w, h, anch, sw, sh)};
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // APB write; only issued while nothing is in flight
  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_REF_W) ref_w_q = val[13:0];
    else ref_h_q = val[13:0];
    @(posedge clk);
  endtask

  task automatic set_reference(logic [13:0] rw, logic [13:0] rh);
    drain();
    write_reg(REG_REF_W, {18'h3FFFF, rw});
    write_reg(REG_REF_H, {18'h2AAAA, rh});
  endtask

  task automatic send_random(int mode);
    logic [15:0] x, y, w, h;
    logic [13:0] sw, sh;
    if (mode == 0) begin
      // Plausible layouts: position and size each within the reference space
      x = 16'($urandom_range(ref_w_q)); y = 16'($urandom_range(ref_h_q));
      w = 16'($urandom_range(ref_w_q)); h = 16'($urandom_range(ref_h_q));
      sw = 14'($urandom_range(16383, 1)); sh = 14'($urandom_range(16383, 1));
    end else begin
      x = 16'($urandom); y = 16'($urandom); w = 16'($urandom); h = 16'($urandom);
      sw = 14'($urandom); sh = 14'($urandom);
    end
    send_request($urandom_range(15) != 0, x, y, w, h, 3'($urandom_range(7)), sw, sh);
  endtask

  task automatic test_invalid_cases();
    // Reset reference sizes are zero: every result invalid
    send_request(1'b1, 16'd10, 16'd10, 16'd20, 16'd20, ANCH_TL, 14'd100, 14'd100);
    set_reference(14'd640, 14'd480);
    send_request(1'b0, 16'd10, 16'd10, 16'd20, 16'd20, ANCH_CT, 14'd100, 14'd100);
    send_request(1'b1, 16'd10, 16'd10, 16'd20, 16'd20, ANCH_TL, 14'd0, 14'd100);
    send_request(1'b1, 16'd10, 16'd10, 16'd20, 16'd20, ANCH_TL, 14'd100, 14'd0);
  endtask

  task automatic test_anchors_and_extremes();
    logic [2:0] a;
    for (int i = 0; i < 8; i++) begin
      a = i[2:0];
      send_request(1'b1, 16'd33, 16'd17, 16'd101, 16'd57, a, 14'd1920, 14'd1080);
    end
    send_request(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, ANCH_BR,
                 14'h3FFF, 14'h3FFF);
    send_request(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, ANCH_CT,
                 14'h3FFF, 14'h3FFF);
    send_request(1'b1, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, ANCH_CT, 14'd1, 14'd1);
    // Tie of the cross products, and halves to round
    send_request(1'b1, 16'd1, 16'hFFFF, 16'd3, 16'hFFFD, ANCH_TL, 14'd320, 14'd240);
    send_request(1'b1, 16'd5, 16'd7, 16'd9, 16'd11, ANCH_BL, 14'd960, 14'd240);
    set_reference(14'd1, 14'd1);
    send_request(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, ANCH_TR,
                 14'h3FFF, 14'h3FFF);
    set_reference(14'h3FFF, 14'h3FFF);
    send_request(1'b1, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFF, ANCH_CT, 14'd1, 14'd2);
    send_request(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, ANCH_BR, 14'd2, 14'd1);
  endtask

  task automatic test_random_layouts();
    logic [13:0] sizes[6] = '{14'd640, 14'd7, 14'd1, 14'h3FFF, 14'd1920, 14'd0};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_reference(14'd1024, 14'd0);
      else set_reference(sizes[ph], sizes[(ph + 2) % 5]);
      steady = (ph == 2);
      for (int i = 0; i < 180; i++) send_random($urandom_range(3) == 0);
      if (ph == 3) begin
        // Hold off until every result is back, then resume
        start <= 1'b0;
        while (pending_rects.size() != 0) @(posedge clk);
        for (int i = 0; i < 20; i++) send_random(0);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_invalid_cases();
    test_anchors_and_extremes();
    test_random_layouts();
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: anchored_rect_scaler.f
rtl/core/arsc_pkg.sv
rtl/core/arsc_div.sv
rtl/core/anchored_rect_scaler.sv
tb/sv/anchored_rect_scaler_test.sv
